/* sv/tlik_pkg.sv */
package tlik_pkg;

    // fixed field widths
    localparam int COORD_W = 18;
    localparam int LEN_W   = 16;
    localparam int ANG_W   = 19;
    localparam int CFG_W   = 19;
    localparam int IDX_W   = 3;

    localparam int FRAC_BITS_DEF = 16;

    // CORDIC angle accumulator: Q30 radians
    localparam int ANG_BITS     = 30;
    localparam int Z_W          = 34;
    localparam int CORDIC_STEPS = 31;
    localparam int PRESCALE     = 20;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // register indexes
    localparam logic [IDX_W-1:0] REG_BASE_HEIGHT     = 3'd0;
    localparam logic [IDX_W-1:0] REG_UPPER_LINK      = 3'd1;
    localparam logic [IDX_W-1:0] REG_FORE_LINK       = 3'd2;
    localparam logic [IDX_W-1:0] REG_SHOULDER_OFFSET = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHOULDER_MIN    = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHOULDER_MAX    = 3'd5;
    localparam logic [IDX_W-1:0] REG_ELBOW_MIN       = 3'd6;
    localparam logic [IDX_W-1:0] REG_ELBOW_MAX       = 3'd7;

    // reset values
    localparam logic [LEN_W-1:0]        BASE_HEIGHT_RST     = 16'd11993;
    localparam logic [LEN_W-1:0]        UPPER_LINK_RST      = 16'd14418;
    localparam logic [LEN_W-1:0]        FORE_LINK_RST       = 16'd13107;
    localparam logic signed [CFG_W-1:0] SHOULDER_OFFSET_RST = 19'sd23724;
    localparam logic signed [CFG_W-1:0] SHOULDER_MIN_RST    = -19'sd32768;
    localparam logic signed [CFG_W-1:0] SHOULDER_MAX_RST    = 19'sd52429;
    localparam logic signed [CFG_W-1:0] ELBOW_MIN_RST       = -19'sd65536;
    localparam logic signed [CFG_W-1:0] ELBOW_MAX_RST       = 19'sd6554;

    // atan(2^-i) in Q30; past the table it equals 2^-i
    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        logic signed [Z_W-1:0] t;
        case (i)
            0:       t = Z_W'(64'sd843314857);
            1:       t = Z_W'(64'sd497837829);
            2:       t = Z_W'(64'sd263043837);
            3:       t = Z_W'(64'sd133525159);
            4:       t = Z_W'(64'sd67021687);
            5:       t = Z_W'(64'sd33543516);
            6:       t = Z_W'(64'sd16775851);
            7:       t = Z_W'(64'sd8388437);
            8:       t = Z_W'(64'sd4194283);
            9:       t = Z_W'(64'sd2097149);
            default: t = Z_W'(64'sd1 <<< (ANG_BITS - i));
        endcase
        return t;
    endfunction

endpackage

/* sv/tlik_delay.sv */
module tlik_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [0:N-1];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < N; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[N-1];

endmodule

/* sv/tlik_isqrt.sv */
module tlik_isqrt #(
    parameter int IN_W = 36
) (
    input  logic                    clk,
    input  logic [IN_W-1:0]         radicand,
    output logic [(IN_W+1)/2-1:0]   root
);

    localparam int OUT_W = (IN_W + 1) / 2;
    localparam int STEPS = OUT_W;
    localparam int RW    = IN_W + 2;

    logic [IN_W-1:0] n_reg [0:STEPS-1];
    logic [RW-1:0]   r_reg [0:STEPS-1];

    // one root bit per cell, most significant first
    for (genvar j = 0; j < STEPS; j++)
    begin : g_cell
        localparam int K = STEPS - 1 - j;
        logic [IN_W-1:0] n_in;
        logic [RW-1:0]   r_in;
        logic [IN_W-1:0] n_next;
        logic [RW-1:0]   r_next;
        logic [RW-1:0]   trial;

        if (j == 0)
        begin : g_first
            assign n_in = radicand;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign n_in = n_reg[j-1];
            assign r_in = r_reg[j-1];
        end

        always_comb
        begin
            trial = r_in + (RW'(1) << (2 * K));
            if (RW'(n_in) >= trial)
            begin
                n_next = n_in - trial[IN_W-1:0];
                r_next = (r_in >> 1) + (RW'(1) << (2 * K));
            end
            else
            begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[j] <= n_next;
            r_reg[j] <= r_next;
        end
    end

    assign root = r_reg[STEPS-1][OUT_W-1:0];

endmodule

/* sv/tlik_divider.sv */
module tlik_divider #(
    parameter int FRAC  = 16,
    parameter int NUM_W = 36,
    parameter int DEN_W = 34
) (
    input  logic                    clk,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic signed [FRAC+1:0]  cosine
);

    localparam int QW = FRAC + 2;
    localparam int NW = NUM_W + FRAC + 1;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic zden;
    } div_flag_t;

    logic [NW-1:0]    rem_reg  [0:QW];
    logic [QW-1:0]    q_reg    [0:QW];
    logic [DEN_W-1:0] den_reg  [0:QW];
    div_flag_t        flag_reg [0:QW];
    logic signed [FRAC+1:0] cosine_reg;

    logic [NUM_W-1:0] mag;
    logic [NW-1:0]    n_init;
    div_flag_t        flag_init;

    // rounding bias folded into the dividend; a quotient above 2^FRAC saturates to 2^FRAC
    always_comb
    begin
        mag            = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        n_init         = (NW'(mag) << FRAC) + NW'(den >> 1);
        flag_init.neg  = num[NUM_W-1];
        flag_init.ovf  = (n_init >> QW) >= NW'(den);
        flag_init.zden = (den == '0);
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= n_init;
        q_reg[0]    <= '0;
        den_reg[0]  <= den;
        flag_reg[0] <= flag_init;
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_cell
        localparam int K = QW - 1 - j;
        logic [NW-1:0] dsh;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] q_next;

        always_comb
        begin
            dsh      = NW'(den_reg[j]) << K;
            rem_next = rem_reg[j];
            q_next   = q_reg[j];
            if (rem_reg[j] >= dsh)
            begin
                rem_next  = rem_reg[j] - dsh;
                q_next[K] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1]  <= rem_next;
            q_reg[j+1]    <= q_next;
            den_reg[j+1]  <= den_reg[j];
            flag_reg[j+1] <= flag_reg[j];
        end
    end

    logic [QW-1:0]          mag_q;
    logic signed [FRAC+1:0] cos_next;

    always_comb
    begin
        if (flag_reg[QW].ovf || (q_reg[QW] > (QW'(1) << FRAC)))
        begin
            mag_q = QW'(1) << FRAC;
        end
        else
        begin
            mag_q = q_reg[QW];
        end
        if (flag_reg[QW].zden)
        begin
            cos_next = (FRAC+2)'(1) << FRAC;
        end
        else if (flag_reg[QW].neg)
        begin
            cos_next = -$signed(mag_q);
        end
        else
        begin
            cos_next = $signed(mag_q);
        end
    end

    always_ff @(posedge clk)
    begin
        cosine_reg <= cos_next;
    end

    assign cosine = cosine_reg;

endmodule

/* sv/tlik_atan2.sv */
module tlik_atan2 #(
    parameter int IN_W = 18,
    parameter int FRAC = 16
) (
    input  logic                   clk,
    input  logic signed [IN_W-1:0] y,
    input  logic signed [IN_W-1:0] x,
    output logic signed [FRAC+3:0] angle
);

    localparam int CW    = IN_W + tlik_pkg::PRESCALE + 3;
    localparam int AW    = FRAC + 4;
    localparam int ZW    = tlik_pkg::Z_W;
    localparam int STEPS = tlik_pkg::CORDIC_STEPS;
    localparam int SH    = tlik_pkg::ANG_BITS - FRAC;

    localparam logic signed [ZW-1:0] PI_Z = ZW'(tlik_pkg::PI_Q30);

    logic signed [CW-1:0] x_reg [0:STEPS];
    logic signed [CW-1:0] y_reg [0:STEPS];
    logic signed [ZW-1:0] z_reg [0:STEPS];
    logic signed [AW-1:0] angle_reg;

    logic signed [CW-1:0] xs, ys, x0, y0;
    logic signed [ZW-1:0] z0;

    // left half plane folds by pi
    always_comb
    begin
        xs = CW'(x) <<< tlik_pkg::PRESCALE;
        ys = CW'(y) <<< tlik_pkg::PRESCALE;
        x0 = xs;
        y0 = ys;
        z0 = '0;
        if (xs < 0)
        begin
            x0 = -xs;
            y0 = -ys;
            z0 = (-ys <= 0) ? PI_Z : -PI_Z;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= x0;
        y_reg[0] <= y0;
        z_reg[0] <= z0;
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        logic signed [CW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;

        // a zeroed y stops the rotation for good
        always_comb
        begin
            x_next = x_reg[i];
            y_next = y_reg[i];
            z_next = z_reg[i];
            if (y_reg[i] > 0)
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + tlik_pkg::atan_step(i);
            end
            else if (y_reg[i] < 0)
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - tlik_pkg::atan_step(i);
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1] <= x_next;
            y_reg[i+1] <= y_next;
            z_reg[i+1] <= z_next;
        end
    end

    logic signed [ZW:0] z_ext, z_rnd;

    // round to nearest, ties away from zero
    always_comb
    begin
        z_ext = (ZW+1)'(z_reg[STEPS]);
        if (z_ext >= 0)
        begin
            z_rnd = (z_ext + ((ZW+1)'(1) <<< (SH - 1))) >>> SH;
        end
        else
        begin
            z_rnd = -((-z_ext + ((ZW+1)'(1) <<< (SH - 1))) >>> SH);
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= z_rnd[AW-1:0];
    end

    assign angle = angle_reg;

endmodule

/* sv/three_link_arm_ik_solver.sv */
// Inverse kinematics for a base-yaw / shoulder / elbow arm. A request is taken
// on every clock edge where start is high (busy never rises), so targets may be
// issued back to back, one per cycle. Each request yields exactly one result:
// base_yaw, shoulder_angle and elbow_angle appear together for one cycle with
// done high, in request order. The result strobe cannot be held off, so the
// receiver must capture it in that cycle. A request walks through a chain of
// root, CORDIC and divider cells, each of them registered: radius root,
// distance root, cosine divider, sine root and the final CORDIC. Coordinates
// are in 2^-FRAC_BITS m, angles in 2^-FRAC_BITS rad. Write the configuration
// registers only while no request is in flight.
module three_link_arm_ik_solver #(
    parameter int FRAC_BITS = tlik_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [tlik_pkg::COORD_W-1:0]  goal_x,
    input  logic signed [tlik_pkg::COORD_W-1:0]  goal_y,
    input  logic signed [tlik_pkg::COORD_W-1:0]  goal_z,
    input  logic                                 cfg_we,
    input  logic [tlik_pkg::IDX_W-1:0]           cfg_index,
    input  logic [tlik_pkg::CFG_W-1:0]           cfg_data,
    output logic                                 done,
    output logic signed [tlik_pkg::ANG_W-1:0]    base_yaw,
    output logic signed [tlik_pkg::ANG_W-1:0]    shoulder_angle,
    output logic signed [tlik_pkg::ANG_W-1:0]    elbow_angle
);

    localparam int CW_IN = tlik_pkg::COORD_W;
    localparam int LW    = tlik_pkg::LEN_W;
    localparam int OW    = tlik_pkg::ANG_W;
    localparam int AW    = FRAC_BITS + 4;
    localparam int SW    = ((AW > OW) ? AW : OW) + 2;
    localparam int SH    = tlik_pkg::ANG_BITS - FRAC_BITS;

    // datapath widths
    localparam int SXY_W = 2 * CW_IN;              // x^2 + y^2
    localparam int R_W   = (SXY_W + 1) / 2;        // horizontal radius
    localparam int ZO_W  = CW_IN + 1;              // height above shoulder
    localparam int SRZ_W = SXY_W + 1;              // r^2 + zo^2
    localparam int D_W   = (SRZ_W + 1) / 2;        // shoulder distance
    localparam int DC_W  = LW + 1;                 // capped distance
    localparam int NUM_W = 2 * LW + 4;
    localparam int DEN_W = 2 * LW + 2;
    localparam int C_W   = FRAC_BITS + 2;          // cosine
    localparam int V_W   = 2 * FRAC_BITS + 1;      // 1 - c^2
    localparam int S_W   = (V_W + 1) / 2;          // sine

    // stage numbers, counted from the accepting edge
    localparam int CL    = tlik_pkg::CORDIC_STEPS + 2;
    localparam int SQ1   = R_W;
    localparam int SQ2   = D_W;
    localparam int SQ3   = S_W;
    localparam int DL    = FRAC_BITS + 4;
    localparam int RS    = 1 + SQ1;
    localparam int DS    = RS + 1 + SQ2;
    localparam int NS    = DS + 3;
    localparam int CS    = NS + DL;
    localparam int SS    = CS + 1 + SQ3;
    localparam int AS    = SS + CL;
    localparam int TOTAL = AS + 2;

    localparam logic [DC_W-1:0] MARGIN = DC_W'((2 ** FRAC_BITS + 500) / 1000);
    localparam logic signed [SW-1:0] HALF_R =
        SW'((tlik_pkg::HALF_PI_Q30 + (64'sd1 <<< (SH - 1))) >>> SH);
    localparam logic signed [AW-1:0] PI_R =
        AW'((tlik_pkg::PI_Q30 + (64'sd1 <<< (SH - 1))) >>> SH);
    localparam logic signed [2*FRAC_BITS+3:0] ONE_SQ =
        (2*FRAC_BITS+4)'(1) <<< (2 * FRAC_BITS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LW-1:0]                      base_height_reg;
    logic [LW-1:0]                      upper_link_reg;
    logic [LW-1:0]                      fore_link_reg;
    logic signed [tlik_pkg::CFG_W-1:0]  shoulder_offset_reg;
    logic signed [tlik_pkg::CFG_W-1:0]  shoulder_min_reg;
    logic signed [tlik_pkg::CFG_W-1:0]  shoulder_max_reg;
    logic signed [tlik_pkg::CFG_W-1:0]  elbow_min_reg;
    logic signed [tlik_pkg::CFG_W-1:0]  elbow_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_height_reg     <= tlik_pkg::BASE_HEIGHT_RST;
            upper_link_reg      <= tlik_pkg::UPPER_LINK_RST;
            fore_link_reg       <= tlik_pkg::FORE_LINK_RST;
            shoulder_offset_reg <= tlik_pkg::SHOULDER_OFFSET_RST;
            shoulder_min_reg    <= tlik_pkg::SHOULDER_MIN_RST;
            shoulder_max_reg    <= tlik_pkg::SHOULDER_MAX_RST;
            elbow_min_reg       <= tlik_pkg::ELBOW_MIN_RST;
            elbow_max_reg       <= tlik_pkg::ELBOW_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tlik_pkg::REG_BASE_HEIGHT:     base_height_reg     <= cfg_data[LW-1:0];
                tlik_pkg::REG_UPPER_LINK:      upper_link_reg      <= cfg_data[LW-1:0];
                tlik_pkg::REG_FORE_LINK:       fore_link_reg       <= cfg_data[LW-1:0];
                tlik_pkg::REG_SHOULDER_OFFSET: shoulder_offset_reg <= cfg_data;
                tlik_pkg::REG_SHOULDER_MIN:    shoulder_min_reg    <= cfg_data;
                tlik_pkg::REG_SHOULDER_MAX:    shoulder_max_reg    <= cfg_data;
                tlik_pkg::REG_ELBOW_MIN:       elbow_min_reg       <= cfg_data;
                tlik_pkg::REG_ELBOW_MAX:       elbow_max_reg       <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request tracking: fixed-latency pipe, a valid bit per stage
    // ------------------------------------------------------------------
    logic             accept;
    logic [TOTAL:0]   vld_reg;
    logic [TOTAL:0]   vld_next;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign vld_next = {vld_reg[TOTAL-1:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: capture, camera x/y swapped into arm frame
    // ------------------------------------------------------------------
    logic signed [CW_IN-1:0] ax_reg, ay_reg, az_reg;

    always_ff @(posedge clk)
    begin
        ax_reg <= goal_y;
        ay_reg <= goal_x;
        az_reg <= goal_z;
    end

    // base yaw
    logic signed [AW-1:0] yaw_w, yaw_dly_w;

    tlik_atan2 #(.IN_W(CW_IN), .FRAC(FRAC_BITS)) u_yaw (
        .clk   (clk),
        .y     (ay_reg),
        .x     (ax_reg),
        .angle (yaw_w)
    );

    tlik_delay #(.W(AW), .N(AS + 1 - CL)) u_yaw_dly (
        .clk  (clk),
        .din  (yaw_w),
        .dout (yaw_dly_w)
    );

    // ------------------------------------------------------------------
    // Stage 1: x^2 + y^2, height relative to shoulder
    // ------------------------------------------------------------------
    logic signed [SXY_W-1:0] ax_sq, ay_sq;
    logic [SXY_W-1:0]        sum_xy_next, sum_xy_reg;
    logic signed [ZO_W-1:0]  zo_next, zo_reg;

    assign ax_sq       = ax_reg * ax_reg;
    assign ay_sq       = ay_reg * ay_reg;
    assign sum_xy_next = ax_sq + ay_sq;
    assign zo_next     = {az_reg[CW_IN-1], az_reg} - {{(ZO_W-LW){1'b0}}, base_height_reg};

    always_ff @(posedge clk)
    begin
        sum_xy_reg <= sum_xy_next;
        zo_reg     <= zo_next;
    end

    logic [R_W-1:0]         r_w;
    logic signed [ZO_W-1:0] zo_dly_w;

    tlik_isqrt #(.IN_W(SXY_W)) u_root_xy (
        .clk      (clk),
        .radicand (sum_xy_reg),
        .root     (r_w)
    );

    tlik_delay #(.W(ZO_W), .N(SQ1)) u_zo_dly (
        .clk  (clk),
        .din  (zo_reg),
        .dout (zo_dly_w)
    );

    // elevation angle beta
    logic signed [AW-1:0] beta_w, beta_dly_w;

    tlik_atan2 #(.IN_W(ZO_W), .FRAC(FRAC_BITS)) u_beta (
        .clk   (clk),
        .y     (zo_dly_w),
        .x     ($signed({1'b0, r_w})),
        .angle (beta_w)
    );

    tlik_delay #(.W(AW), .N(AS - RS - CL)) u_beta_dly (
        .clk  (clk),
        .din  (beta_w),
        .dout (beta_dly_w)
    );

    // ------------------------------------------------------------------
    // Shoulder-to-target distance
    // ------------------------------------------------------------------
    logic [SRZ_W-1:0]          r_sq;
    logic signed [SRZ_W:0]     zo_sq;
    logic [SRZ_W-1:0]          srz_next, srz_reg;

    assign r_sq     = SRZ_W'(r_w) * SRZ_W'(r_w);
    assign zo_sq    = zo_dly_w * zo_dly_w;
    assign srz_next = r_sq + zo_sq[SRZ_W-1:0];

    always_ff @(posedge clk)
    begin
        srz_reg <= srz_next;
    end

    logic [D_W-1:0] d_w;

    tlik_isqrt #(.IN_W(SRZ_W)) u_root_d (
        .clk      (clk),
        .radicand (srz_reg),
        .root     (d_w)
    );

    // reach cap: just short of full stretch
    logic [DC_W-1:0] reach;
    logic [DC_W-1:0] dcap_next, dcap_reg;

    always_comb
    begin
        reach = DC_W'(upper_link_reg) + DC_W'(fore_link_reg);
        if (d_w > D_W'(reach))
        begin
            dcap_next = (reach >= MARGIN) ? reach - MARGIN : '0;
        end
        else
        begin
            dcap_next = d_w[DC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        dcap_reg <= dcap_next;
    end

    // products, then law-of-cosines terms
    logic [2*DC_W-1:0]   dsq_reg;
    logic [LW+DC_W-1:0]  l2d_reg;
    logic [2*LW-1:0]     l2sq_reg, l3sq_reg, l23_reg;

    always_ff @(posedge clk)
    begin
        dsq_reg  <= (2*DC_W)'(dcap_reg) * (2*DC_W)'(dcap_reg);
        l2d_reg  <= (LW+DC_W)'(upper_link_reg) * (LW+DC_W)'(dcap_reg);
        l2sq_reg <= (2*LW)'(upper_link_reg) * (2*LW)'(upper_link_reg);
        l3sq_reg <= (2*LW)'(fore_link_reg) * (2*LW)'(fore_link_reg);
        l23_reg  <= (2*LW)'(upper_link_reg) * (2*LW)'(fore_link_reg);
    end

    logic signed [NUM_W-1:0] num_g_reg, num_a_reg;
    logic [DEN_W-1:0]        den_g_reg, den_a_reg;

    always_ff @(posedge clk)
    begin
        num_g_reg <= NUM_W'(l2sq_reg) + NUM_W'(l3sq_reg) - NUM_W'(dsq_reg);
        num_a_reg <= NUM_W'(l2sq_reg) + NUM_W'(dsq_reg) - NUM_W'(l3sq_reg);
        den_g_reg <= DEN_W'({l23_reg, 1'b0});
        den_a_reg <= DEN_W'({l2d_reg, 1'b0});
    end

    logic signed [C_W-1:0] cg_w, ca_w;

    tlik_divider #(.FRAC(FRAC_BITS), .NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_g (
        .clk    (clk),
        .num    (num_g_reg),
        .den    (den_g_reg),
        .cosine (cg_w)
    );

    tlik_divider #(.FRAC(FRAC_BITS), .NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_a (
        .clk    (clk),
        .num    (num_a_reg),
        .den    (den_a_reg),
        .cosine (ca_w)
    );

    // ------------------------------------------------------------------
    // acos(c) = atan2(sqrt(1 - c^2), c)
    // ------------------------------------------------------------------
    logic signed [2*FRAC_BITS+3:0] cg_sq, ca_sq;
    logic [V_W-1:0]                v_g_next, v_a_next, v_g_reg, v_a_reg;
    logic signed [C_W-1:0]         cg_reg, ca_reg;

    assign cg_sq    = cg_w * cg_w;
    assign ca_sq    = ca_w * ca_w;
    assign v_g_next = V_W'(ONE_SQ - cg_sq);
    assign v_a_next = V_W'(ONE_SQ - ca_sq);

    always_ff @(posedge clk)
    begin
        v_g_reg <= v_g_next;
        v_a_reg <= v_a_next;
        cg_reg  <= cg_w;
        ca_reg  <= ca_w;
    end

    logic [S_W-1:0]        sg_w, sa_w;
    logic signed [C_W-1:0] cg_dly_w, ca_dly_w;

    tlik_isqrt #(.IN_W(V_W)) u_root_sg (
        .clk      (clk),
        .radicand (v_g_reg),
        .root     (sg_w)
    );

    tlik_isqrt #(.IN_W(V_W)) u_root_sa (
        .clk      (clk),
        .radicand (v_a_reg),
        .root     (sa_w)
    );

    tlik_delay #(.W(C_W), .N(SQ3)) u_cg_dly (
        .clk  (clk),
        .din  (cg_reg),
        .dout (cg_dly_w)
    );

    tlik_delay #(.W(C_W), .N(SQ3)) u_ca_dly (
        .clk  (clk),
        .din  (ca_reg),
        .dout (ca_dly_w)
    );

    logic signed [AW-1:0] gamma_w, alpha_w;

    tlik_atan2 #(.IN_W(C_W), .FRAC(FRAC_BITS)) u_gamma (
        .clk   (clk),
        .y     ($signed({1'b0, sg_w})),
        .x     (cg_dly_w),
        .angle (gamma_w)
    );

    tlik_atan2 #(.IN_W(C_W), .FRAC(FRAC_BITS)) u_alpha (
        .clk   (clk),
        .y     ($signed({1'b0, sa_w})),
        .x     (ca_dly_w),
        .angle (alpha_w)
    );

    // ------------------------------------------------------------------
    // Joint angles, then saturation (upper limit first, lower wins)
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sh_sum_reg, el_diff_reg;

    always_ff @(posedge clk)
    begin
        sh_sum_reg  <= SW'(beta_dly_w) + SW'(alpha_w) - SW'(shoulder_offset_reg);
        el_diff_reg <= HALF_R - SW'(gamma_w);
    end

    logic signed [SW-1:0] sh_lim, el_lim;

    always_comb
    begin
        sh_lim = sh_sum_reg;
        if (sh_lim > SW'(shoulder_max_reg))
        begin
            sh_lim = SW'(shoulder_max_reg);
        end
        if (sh_lim < SW'(shoulder_min_reg))
        begin
            sh_lim = SW'(shoulder_min_reg);
        end
        el_lim = el_diff_reg;
        if (el_lim > SW'(elbow_max_reg))
        begin
            el_lim = SW'(elbow_max_reg);
        end
        if (el_lim < SW'(elbow_min_reg))
        begin
            el_lim = SW'(elbow_min_reg);
        end
    end

    logic signed [OW-1:0] base_yaw_reg, shoulder_angle_reg, elbow_angle_reg;

    always_ff @(posedge clk)
    begin
        base_yaw_reg       <= OW'(yaw_dly_w);
        shoulder_angle_reg <= sh_lim[OW-1:0];
        elbow_angle_reg    <= el_lim[OW-1:0];
    end

    assign done           = vld_reg[TOTAL];
    assign base_yaw       = base_yaw_reg;
    assign shoulder_angle = shoulder_angle_reg;
    assign elbow_angle    = elbow_angle_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[TOTAL-1] |-> (yaw_dly_w <= PI_R && yaw_dly_w >= -PI_R))
        else $error("base yaw outside [-pi, pi]");

    a_shoulder_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (done && shoulder_min_reg <= shoulder_max_reg) |->
        (shoulder_angle >= shoulder_min_reg && shoulder_angle <= shoulder_max_reg))
        else $error("shoulder angle escaped its limits");

    a_elbow_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (done && elbow_min_reg <= elbow_max_reg) |->
        (elbow_angle >= elbow_min_reg && elbow_angle <= elbow_max_reg))
        else $error("elbow angle escaped its limits");

endmodule

/* sim/three_link_arm_ik_solver_test.sv */
module three_link_arm_ik_solver_test;

    // Accepting edge to the edge that ends the done cycle.
    localparam int LATENCY   = 2 * tlik_pkg::FRAC_BITS_DEF + 84;
    localparam int WATCHDOG  = 20000;
    localparam int N_RANDOM  = 530;

    typedef struct packed {
        logic signed [tlik_pkg::ANG_W-1:0] yaw;
        logic signed [tlik_pkg::ANG_W-1:0] shoulder;
        logic signed [tlik_pkg::ANG_W-1:0] elbow;
    } joint_set_t;

    // Joint-angle predictor plus queue of pending joint sets.
    class joint_scoreboard;
        longint base_h, upper_l, fore_l, sh_off, sh_lo, sh_hi, el_lo, el_hi;
        joint_set_t pending[$];
        int errors;

        function void set_reg(logic [tlik_pkg::IDX_W-1:0] idx,
                              logic [tlik_pkg::CFG_W-1:0] d);
            case (idx)
                tlik_pkg::REG_BASE_HEIGHT:     base_h  = longint'(d[tlik_pkg::LEN_W-1:0]);
                tlik_pkg::REG_UPPER_LINK:      upper_l = longint'(d[tlik_pkg::LEN_W-1:0]);
                tlik_pkg::REG_FORE_LINK:       fore_l  = longint'(d[tlik_pkg::LEN_W-1:0]);
                tlik_pkg::REG_SHOULDER_OFFSET: sh_off  = longint'($signed(d));
                tlik_pkg::REG_SHOULDER_MIN:    sh_lo   = longint'($signed(d));
                tlik_pkg::REG_SHOULDER_MAX:    sh_hi   = longint'($signed(d));
                tlik_pkg::REG_ELBOW_MIN:       el_lo   = longint'($signed(d));
                tlik_pkg::REG_ELBOW_MAX:       el_hi   = longint'($signed(d));
                default:                       ;
            endcase
        endfunction

        function void restore_defaults();
            base_h  = tlik_pkg::BASE_HEIGHT_RST;
            upper_l = tlik_pkg::UPPER_LINK_RST;
            fore_l  = tlik_pkg::FORE_LINK_RST;
            sh_off  = tlik_pkg::SHOULDER_OFFSET_RST;
            sh_lo   = tlik_pkg::SHOULDER_MIN_RST;
            sh_hi   = tlik_pkg::SHOULDER_MAX_RST;
            el_lo   = tlik_pkg::ELBOW_MIN_RST;
            el_hi   = tlik_pkg::ELBOW_MAX_RST;
        endfunction

        function longint asr_floor(longint v, int s);
            return v >>> s;
        endfunction

        // round to nearest, ties away from zero
        function longint asr_round(longint v, int s);
            longint h;
            h = longint'(1) << (s - 1);
            return v >= 0 ? (v + h) >>> s : -((-v + h) >>> s);
        endfunction

        function longint isqrt(longint n);
            longint r, b;
            r = 0;
            b = longint'(1) << 62;
            while (b > n) b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function longint vector_angle(longint y, longint x);
            longint z, nx, ny;
            z = 0;
            if (x == 0 && y == 0) return 0;
            x = x <<< tlik_pkg::PRESCALE;
            y = y <<< tlik_pkg::PRESCALE;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = (y <= 0) ? tlik_pkg::PI_Q30 : -tlik_pkg::PI_Q30;
            end
            for (int i = 0; i < tlik_pkg::CORDIC_STEPS; i++)
            begin
                if (y == 0) break;
                if (y > 0)
                begin
                    nx = x + asr_floor(y, i);  ny = y - asr_floor(x, i);
                    z += longint'(tlik_pkg::atan_step(i));
                end
                else
                begin
                    nx = x - asr_floor(y, i);  ny = y + asr_floor(x, i);
                    z -= longint'(tlik_pkg::atan_step(i));
                end
                x = nx;
                y = ny;
            end
            return asr_round(z, tlik_pkg::ANG_BITS - tlik_pkg::FRAC_BITS_DEF);
        endfunction

        function longint cos_ratio(longint num, longint den);
            longint one, mag, q;
            one = longint'(1) << tlik_pkg::FRAC_BITS_DEF;
            if (den <= 0) return one;
            mag = num < 0 ? -num : num;
            q = (mag * one + den / 2) / den;
            if (num < 0) q = -q;
            if (q > one) q = one;
            if (q < -one) q = -one;
            return q;
        endfunction

        function longint inv_cos(longint c);
            longint one;
            one = longint'(1) << tlik_pkg::FRAC_BITS_DEF;
            return vector_angle(isqrt(one * one - c * c), c);
        endfunction

        function longint saturate(longint v, longint lo, longint hi);
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v;
        endfunction

        // camera x/y swap: arm x = goal_y, arm y = goal_x
        function void note_request(longint gx, longint gy, longint gz);
            longint r, zo, d, reach, cg, ca, beta;
            joint_set_t j;
            r = isqrt(gy * gy + gx * gx);
            zo = gz - base_h;
            d = isqrt(r * r + zo * zo);
            reach = upper_l + fore_l;
            if (d > reach)
            begin
                d = reach - ((longint'(1) << tlik_pkg::FRAC_BITS_DEF) + 500) / 1000;
                if (d < 0) d = 0;
            end
            cg = cos_ratio(upper_l * upper_l + fore_l * fore_l - d * d, 2 * upper_l * fore_l);
            ca = cos_ratio(upper_l * upper_l + d * d - fore_l * fore_l, 2 * upper_l * d);
            beta = vector_angle(zo, r);
            j.yaw = tlik_pkg::ANG_W'(vector_angle(gx, gy));
            j.shoulder = tlik_pkg::ANG_W'(saturate(beta + inv_cos(ca) - sh_off, sh_lo, sh_hi));
            j.elbow = tlik_pkg::ANG_W'(saturate(asr_round(tlik_pkg::HALF_PI_Q30,
                                           tlik_pkg::ANG_BITS - tlik_pkg::FRAC_BITS_DEF)
                                           - inv_cos(cg), el_lo, el_hi));
            pending = {pending, j};
        endfunction

        function void check_result(joint_set_t got);
            joint_set_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result yaw=%0d", got.yaw);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.yaw !== e.yaw)
            begin
                $error("base_yaw exp %0d got %0d", e.yaw, got.yaw);
                errors++;
            end
            if (got.shoulder !== e.shoulder)
            begin
                $error("shoulder_angle exp %0d got %0d", e.shoulder, got.shoulder);
                errors++;
            end
            if (got.elbow !== e.elbow)
            begin
                $error("elbow_angle exp %0d got %0d", e.elbow, got.elbow);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [tlik_pkg::COORD_W-1:0] goal_x = '0, goal_y = '0, goal_z = '0;
    logic cfg_we = 1'b0;
    logic [tlik_pkg::IDX_W-1:0] cfg_index = '0;
    logic [tlik_pkg::CFG_W-1:0] cfg_data = '0;
    logic done;
    logic signed [tlik_pkg::ANG_W-1:0] base_yaw, shoulder_angle, elbow_angle;

    joint_scoreboard sb;
    int idle_cycles = 0;

    three_link_arm_ik_solver DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .goal_x(goal_x), .goal_y(goal_y), .goal_z(goal_z),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .base_yaw(base_yaw), .shoulder_angle(shoulder_angle),
        .elbow_angle(elbow_angle)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result capture and watchdog; the watchdog restarts on any accepted request or result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done) sb.check_result('{base_yaw, shoulder_angle, elbow_angle});
            if (done || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Random gap before a request: mostly none or short, a few long.
    task automatic random_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50) n = 0;
        else if (n < 92) n = $urandom_range(1, 4);
        else n = $urandom_range(20, 200);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drive one request; start stays high across back-to-back requests.
    task automatic send_goal(logic signed [tlik_pkg::COORD_W-1:0] gx,
                             logic signed [tlik_pkg::COORD_W-1:0] gy,
                             logic signed [tlik_pkg::COORD_W-1:0] gz, bit with_gap);
        if (with_gap && ($urandom_range(0, 3) != 0))
        begin
            random_gap();
        end
        start <= 1'b1;
        goal_x <= gx;
        goal_y <= gy;
        goal_z <= gz;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(gx, gy, gz);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [tlik_pkg::IDX_W-1:0] idx, logic [tlik_pkg::CFG_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, d);
        @(posedge clk);
    endtask

    function automatic logic signed [tlik_pkg::COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: return tlik_pkg::COORD_W'($urandom);
            1: return tlik_pkg::COORD_W'($signed($urandom_range(0, 60000)) - 30000);
            default: return tlik_pkg::COORD_W'($signed($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    // Mostly reachable targets near the arm, plus full-range noise and near-zero points.
    task automatic random_phase(int count);
        int m;
        for (int i = 0; i < count; i++)
        begin
            m = $urandom_range(0, 9);
            send_goal(rand_coord(m < 2 ? 0 : (m < 9 ? 1 : 2)),
                      rand_coord(m < 2 ? 0 : (m < 9 ? 1 : 2)),
                      rand_coord(m < 2 ? 0 : 1), i % 40 >= 10);
        end
        drain();
    endtask

    localparam logic signed [tlik_pkg::CFG_W-1:0] ANG_LIM = 19'sd205887;

    initial
    begin
        sb = new();
        sb.restore_defaults();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, zero vector, +pi on negative x axis, out of reach, origin.
        send_goal('0, '0, '0, 0);
        send_goal('0, -18'sd1000, 18'sd5000, 0);
        send_goal(18'sd1000, '0, 18'sd11993, 0);
        send_goal(-18'sd131072, -18'sd131072, -18'sd131072, 0);
        send_goal(18'sd131071, 18'sd131071, 18'sd131071, 0);
        send_goal(18'sd131071, -18'sd131072, '0, 1);
        send_goal('0, '0, 18'sd11993, 0);
        send_goal(18'sd5000, 18'sd20000, 18'sd15000, 0);
        send_goal(-18'sd3000, 18'sd10000, -18'sd2000, 1);
        send_goal('0, 18'sd27525, 18'sd11993, 0);
        send_goal(18'sd1, -18'sd1, 18'sd3, 0);
        drain();

        // Pause until all results are in, already done by drain; random run at reset values.
        random_phase(N_RANDOM / 5);

        // Zero-length links: denominators of zero.
        write_reg(tlik_pkg::REG_UPPER_LINK, '0);
        write_reg(tlik_pkg::REG_FORE_LINK, '0);
        write_reg(tlik_pkg::REG_BASE_HEIGHT, 19'd0);
        send_goal('0, '0, '0, 0);
        send_goal(18'sd100, 18'sd200, 18'sd300, 0);
        drain();

        // Maximum sizes and wide-open limits; offset at its extreme.
        write_reg(tlik_pkg::REG_BASE_HEIGHT, 19'd65535);
        write_reg(tlik_pkg::REG_UPPER_LINK, 19'd65535);
        write_reg(tlik_pkg::REG_FORE_LINK, 19'd65535);
        write_reg(tlik_pkg::REG_SHOULDER_OFFSET, ANG_LIM);
        write_reg(tlik_pkg::REG_SHOULDER_MIN, -ANG_LIM);
        write_reg(tlik_pkg::REG_SHOULDER_MAX, ANG_LIM);
        write_reg(tlik_pkg::REG_ELBOW_MIN, -ANG_LIM);
        write_reg(tlik_pkg::REG_ELBOW_MAX, ANG_LIM);
        random_phase(N_RANDOM / 5);

        // Crossed limits (min above max) and negative offset extreme.
        write_reg(tlik_pkg::REG_SHOULDER_OFFSET, -ANG_LIM);
        write_reg(tlik_pkg::REG_SHOULDER_MIN, 19'sd1000);
        write_reg(tlik_pkg::REG_SHOULDER_MAX, -19'sd1000);
        write_reg(tlik_pkg::REG_ELBOW_MIN, ANG_LIM);
        write_reg(tlik_pkg::REG_ELBOW_MAX, -ANG_LIM);
        write_reg(tlik_pkg::REG_UPPER_LINK, 19'd1);
        write_reg(tlik_pkg::REG_FORE_LINK, 19'd1);
        random_phase(N_RANDOM / 10);

        // Random legal settings, redrawn for each of four phases.
        for (int p = 0; p < 4; p++)
        begin
            write_reg(tlik_pkg::REG_BASE_HEIGHT, 19'($urandom_range(0, 65535)));
            write_reg(tlik_pkg::REG_UPPER_LINK, 19'($urandom_range(1, 65535)));
            write_reg(tlik_pkg::REG_FORE_LINK, 19'($urandom_range(1, 65535)));
            write_reg(tlik_pkg::REG_SHOULDER_OFFSET,
                      19'($signed($urandom_range(0, 411774)) - 205887));
            write_reg(tlik_pkg::REG_SHOULDER_MIN,
                      19'($signed($urandom_range(0, 205887)) - 205887));
            write_reg(tlik_pkg::REG_SHOULDER_MAX, 19'($urandom_range(0, 205887)));
            write_reg(tlik_pkg::REG_ELBOW_MIN,
                      19'($signed($urandom_range(0, 205887)) - 205887));
            write_reg(tlik_pkg::REG_ELBOW_MAX, 19'($urandom_range(0, 205887)));
            random_phase(N_RANDOM / 8);
        end

        // Wait out the pipeline in case anything is still in flight.
        repeat (LATENCY + 20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
